>>> rtl/lps_pkg.sv
`timescale 1ns / 1ps

package lps_pkg;

	localparam int DELAY_W = 10;
	localparam int LEVEL_W = 7;
	localparam int INDEX_W = 4;
	localparam int FLAGS_W = 4;

	// operation codes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_COMMAND = 1'b1;

	// command flag positions, lowest set bit wins
	localparam int CMD_OFF     = 0;
	localparam int CMD_FAST    = 1;
	localparam int CMD_SLOW    = 2;
	localparam int CMD_BREATHE = 3;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_FAST    = 2'd1,
		MODE_SLOW    = 2'd2,
		MODE_BREATHE = 2'd3
	} mode_t;

	typedef struct packed {
		logic [FLAGS_W-1:0] command_flags;
		logic               operation;
	} in_item_t;

	typedef struct packed {
		logic               running;
		logic [LEVEL_W-1:0] duty_percent;
	} result_t;

	typedef struct packed {
		logic [DELAY_W-1:0] delay_ms;
		logic [LEVEL_W-1:0] level;
	} step_t;

	function automatic logic [INDEX_W-1:0] step_count(input mode_t mode);
		logic [INDEX_W-1:0] n;
		unique case (mode)
			MODE_FAST: n = INDEX_W'(8);
			MODE_SLOW: n = INDEX_W'(2);
			default:   n = INDEX_W'(11);
		endcase
		return n;
	endfunction

	function automatic step_t step_lookup(input mode_t mode, input logic [INDEX_W-1:0] idx);
		step_t s;
		s = '{delay_ms: DELAY_W'(50), level: LEVEL_W'(0)};
		unique case (mode)
			MODE_FAST: begin
				unique case (idx)
					4'd0, 4'd2, 4'd4, 4'd6: s = '{DELAY_W'(50), LEVEL_W'(100)};
					4'd7:                   s = '{DELAY_W'(500), LEVEL_W'(0)};
					default:                s = '{DELAY_W'(50), LEVEL_W'(0)};
				endcase
			end
			MODE_SLOW: begin
				unique case (idx)
					4'd0:    s = '{DELAY_W'(600), LEVEL_W'(100)};
					default: s = '{DELAY_W'(600), LEVEL_W'(0)};
				endcase
			end
			default: begin
				unique case (idx)
					4'd0, 4'd8: s = '{DELAY_W'(50), LEVEL_W'(20)};
					4'd1, 4'd7: s = '{DELAY_W'(50), LEVEL_W'(40)};
					4'd2, 4'd6: s = '{DELAY_W'(50), LEVEL_W'(60)};
					4'd3, 4'd5: s = '{DELAY_W'(50), LEVEL_W'(80)};
					4'd4:       s = '{DELAY_W'(50), LEVEL_W'(100)};
					4'd9:       s = '{DELAY_W'(50), LEVEL_W'(10)};
					4'd10:      s = '{DELAY_W'(500), LEVEL_W'(1)};
					default:    s = '{DELAY_W'(50), LEVEL_W'(20)};
				endcase
			end
		endcase
		return s;
	endfunction

endpackage

>>> rtl/lps_seq_core.sv
`timescale 1ns / 1ps

module lps_seq_core #(
	parameter int DUTY_FULL_SCALE = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  lps_pkg::in_item_t item,
	output lps_pkg::result_t  result
);

	localparam int LW = lps_pkg::LEVEL_W;
	localparam int IW = lps_pkg::INDEX_W;
	localparam int DW = lps_pkg::DELAY_W;
	localparam int LEVELS = 1 << LW;

	typedef logic [LW-1:0] pct_tab_t [LEVELS];

	// level -> percent, built at elaboration
	function automatic pct_tab_t build_pct_tab();
		pct_tab_t tab;
		int lvl;
		for (int i = 0; i < LEVELS; i++) begin
			lvl = (i > DUTY_FULL_SCALE) ? DUTY_FULL_SCALE : i;
			tab[i] = LW'((lvl * 100) / DUTY_FULL_SCALE);
		end
		return tab;
	endfunction

	localparam pct_tab_t PCT_TAB = build_pct_tab();

	lps_pkg::mode_t  mode_q, mode_d;
	logic [IW-1:0]   step_q, step_d;
	logic [DW-1:0]   ticks_q, ticks_d;
	logic [LW-1:0]   duty_q, duty_d;

	logic [DW-1:0]   ticks_dec;
	logic [IW-1:0]   len;
	logic [IW-1:0]   idx;
	logic [IW:0]     idx_inc;
	lps_pkg::step_t  entry;

	always_comb begin
		ticks_dec = (ticks_q != '0) ? ticks_q - DW'(1) : '0;
		len       = lps_pkg::step_count(mode_q);
		idx       = (step_q >= len) ? '0 : step_q;
		idx_inc   = {1'b0, idx} + (IW+1)'(1);
		entry     = lps_pkg::step_lookup(mode_q, idx);
	end

	always_comb begin
		mode_d  = mode_q;
		step_d  = step_q;
		ticks_d = ticks_q;
		duty_d  = duty_q;
		if (item.operation == lps_pkg::OP_COMMAND) begin
			priority if (item.command_flags[lps_pkg::CMD_OFF]) begin
				mode_d  = lps_pkg::MODE_IDLE;
				ticks_d = '0;
				duty_d  = '0;
			end else if (item.command_flags[lps_pkg::CMD_FAST]) begin
				mode_d  = lps_pkg::MODE_FAST;
				step_d  = '0;
				ticks_d = DW'(1);
			end else if (item.command_flags[lps_pkg::CMD_SLOW]) begin
				mode_d  = lps_pkg::MODE_SLOW;
				step_d  = '0;
				ticks_d = DW'(1);
			end else if (item.command_flags[lps_pkg::CMD_BREATHE]) begin
				mode_d  = lps_pkg::MODE_BREATHE;
				step_d  = '0;
				ticks_d = DW'(1);
			end else begin
				// no flag set: state holds
				mode_d  = mode_q;
			end
		end else if (mode_q != lps_pkg::MODE_IDLE) begin
			ticks_d = ticks_dec;
			if (ticks_dec == '0) begin
				duty_d  = entry.level;
				ticks_d = entry.delay_ms;
				step_d  = (idx_inc >= {1'b0, len}) ? '0 : idx_inc[IW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lps_pkg::MODE_IDLE;
			step_q  <= '0;
			ticks_q <= '0;
			duty_q  <= '0;
		end else if (en) begin
			mode_q  <= mode_d;
			step_q  <= step_d;
			ticks_q <= ticks_d;
			duty_q  <= duty_d;
		end
	end

	assign result.duty_percent = PCT_TAB[duty_d];
	assign result.running      = (mode_d != lps_pkg::MODE_IDLE);

endmodule

>>> rtl/led_pattern_sequencer_top.sv
`timescale 1ns / 1ps

// LED pattern sequencer: every input beat is a millisecond tick or a command
// (off, fast, slow, breathe; lowest flag wins) and yields exactly one output
// beat with the PWM duty in percent and a running flag. One beat is taken per
// clock while m_axis_tready does not stall the output; a beat is held in the
// input register, where the countdown and table step are applied, and then
// moves on to the output register.

module led_pattern_sequencer_top #(
	parameter int DUTY_FULL_SCALE = 100
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [0] operation, [4:1] command_flags, [7:5] zero
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // [6:0] duty_percent, [7] running
);

	logic              valid_s1;
	lps_pkg::in_item_t item_s1;
	logic              valid_s2;
	lps_pkg::result_t  result_s2;
	lps_pkg::result_t  core_result;
	logic              advance;
	logic              take;

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign take          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.operation     <= s_axis_tdata[0];
			item_s1.command_flags <= s_axis_tdata[4:1];
		end
	end

	lps_seq_core #(
		.DUTY_FULL_SCALE(DUTY_FULL_SCALE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (take),
		.item   (item_s1),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_s2 <= core_result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {result_s2.running, result_s2.duty_percent};

endmodule
